// ----- sv/cpf_pkg.sv -----
`default_nettype none
package cpf_pkg;

  localparam int COUNT_W = 16;
  localparam int FILL_W = 3;
  localparam int CHUNK_DEPTH = 7;
  localparam int PAYLOAD_BYTES = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_PACKET_BYTES_DEF = 65535;
  localparam int SHORT_OFFSET_LIMIT_DEF = 255;
  localparam int SHORT_PACKET_MAX = 6;
  localparam int SHORT_CHUNK_CAP = 7;
  localparam int LONG_CHUNK_CAP = 6;
  localparam int PROCESS_LEN = 6;

  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [15:0] CRC_INIT_RESET = 16'h0000;

  typedef enum logic [1:0] {
    REG_OWN_ID,
    REG_CRC_POLY,
    REG_CRC_INIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FILL,
    KIND_FILL_LONG,
    KIND_PROCESS,
    KIND_SHORT
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t                          kind;
    logic [7:0]                           dest;
    logic [3:0]                           len;
    logic [PAYLOAD_BYTES-1:0][7:0]        payload;
    logic                                 done;
  } frame_t;

  // Up to two frames caused by one input byte; the second is always a process frame.
  typedef struct packed {
    frame_t first;
    frame_t second;
    logic   two;
  } result_pair_t;

  // MSB-first CRC-16 update over one byte, implicit x^16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cpf_result_fifo.sv -----
`default_nettype none
module cpf_result_fifo (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire cpf_pkg::result_pair_t push_pair,
  output logic                   full,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cpf_pkg::frame_t        out_frame
);

  cpf_pkg::result_pair_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       sub;
  logic       frame_pop;
  logic       pair_pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_frame = sub ? entries[rd_ptr].second : entries[rd_ptr].first;
  assign frame_pop = out_valid && out_ready;
  // Retire the pair after its last frame is taken.
  assign pair_pop  = frame_pop && (sub || !entries[rd_ptr].two);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pair_pop) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 1'b0;
      end else if (frame_pop) begin
        sub <= 1'b1;
      end
      case ({push, pair_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/can_packet_fragmenter.sv -----
// A frame is registered in the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while the result queue is not full; a closing byte that also
// flushes a chunk yields two frames, which leave the two-entry result queue one after the other.
// Reset (synchronous, active high) clears the packet state, the result queue and the
// configuration registers (own id 0, polynomial 0x1021, initial value 0).
`default_nettype none
module can_packet_fragmenter #(
  parameter int MAX_PACKET_BYTES   = cpf_pkg::MAX_PACKET_BYTES_DEF,
  parameter int SHORT_OFFSET_LIMIT = cpf_pkg::SHORT_OFFSET_LIMIT_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [cpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire [cpf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [7:0]                        data_byte,
  input  wire                              last_byte,
  input  wire [7:0]                        target_id,
  input  wire [7:0]                        command_code,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       frame_kind,
  output logic [7:0]                       dest_id,
  output logic [3:0]                       frame_length,
  output logic [7:0]                       payload_0,
  output logic [7:0]                       payload_1,
  output logic [7:0]                       payload_2,
  output logic [7:0]                       payload_3,
  output logic [7:0]                       payload_4,
  output logic [7:0]                       payload_5,
  output logic [7:0]                       payload_6,
  output logic [7:0]                       payload_7,
  output logic                             packet_done
);

  localparam logic [cpf_pkg::COUNT_W-1:0] MAX_COUNT = cpf_pkg::COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [cpf_pkg::COUNT_W-1:0] OFFSET_LIMIT = cpf_pkg::COUNT_W'(SHORT_OFFSET_LIMIT);

  // Configuration
  logic [7:0]  own_id;
  logic [15:0] crc_poly;
  logic [15:0] crc_init;

  // Packet state
  logic [7:0]                    chunk_bytes [cpf_pkg::CHUNK_DEPTH];
  logic [cpf_pkg::FILL_W-1:0]    chunk_fill;
  logic [cpf_pkg::COUNT_W-1:0]   byte_count;
  logic [15:0]                   running_crc;
  logic [7:0]                    latched_target;
  logic [7:0]                    latched_command;

  logic                          accept;
  logic                          first;
  logic                          take;
  logic [7:0]                    tgt_cur;
  logic [7:0]                    cmd_cur;
  logic [15:0]                   crc_base;
  logic [15:0]                   crc_next;
  logic [cpf_pkg::FILL_W-1:0]    fill_upd;
  logic [cpf_pkg::COUNT_W-1:0]   count_upd;
  logic [cpf_pkg::COUNT_W-1:0]   start;
  logic                          short_start;
  logic                          short_pkt;
  logic                          emit_chunk;
  logic                          emit_proc;
  logic [7:0]                    bytes_upd [cpf_pkg::CHUNK_DEPTH];
  cpf_pkg::frame_t               short_frame;
  cpf_pkg::frame_t               chunk_frame;
  cpf_pkg::frame_t               proc_frame;
  cpf_pkg::result_pair_t         pair;
  logic                          push;
  logic                          fifo_full;
  cpf_pkg::frame_t               out_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id   <= 8'h00;
      crc_poly <= cpf_pkg::CRC_POLY_RESET;
      crc_init <= cpf_pkg::CRC_INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cpf_pkg::REG_OWN_ID:   own_id   <= cfg_data[7:0];
        cpf_pkg::REG_CRC_POLY: crc_poly <= cfg_data;
        cpf_pkg::REG_CRC_INIT: crc_init <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first     = (byte_count == '0) && (chunk_fill == '0);
    tgt_cur   = first ? target_id : latched_target;
    cmd_cur   = first ? command_code : latched_command;
    crc_base  = first ? crc_init : running_crc;
    // Drop bytes past the length limit.
    take      = (byte_count < MAX_COUNT);
    fill_upd  = take ? chunk_fill + 3'd1 : chunk_fill;
    count_upd = take ? byte_count + 16'd1 : byte_count;
    crc_next  = take ? cpf_pkg::crc16_byte(crc_base, data_byte, crc_poly) : crc_base;
    for (int i = 0; i < cpf_pkg::CHUNK_DEPTH; i++) begin
      bytes_upd[i] = (take && chunk_fill == cpf_pkg::FILL_W'(i)) ? data_byte : chunk_bytes[i];
    end
    start       = count_upd - cpf_pkg::COUNT_W'(fill_upd);
    short_start = (start <= OFFSET_LIMIT);
    short_pkt   = last_byte && (count_upd <= cpf_pkg::COUNT_W'(cpf_pkg::SHORT_PACKET_MAX));
    emit_chunk  = !short_pkt && (fill_upd != '0) &&
                  (last_byte || (short_start ? (fill_upd >= 3'(cpf_pkg::SHORT_CHUNK_CAP))
                                             : (fill_upd >= 3'(cpf_pkg::LONG_CHUNK_CAP))));
    emit_proc   = !short_pkt && last_byte;
  end

  always_comb begin
    short_frame         = '0;
    short_frame.kind    = cpf_pkg::KIND_SHORT;
    short_frame.dest    = tgt_cur;
    short_frame.len     = 4'(count_upd[2:0]) + 4'd1;
    short_frame.done    = 1'b1;
    short_frame.payload[0] = cmd_cur;
    for (int j = 0; j < cpf_pkg::CHUNK_DEPTH; j++) begin
      short_frame.payload[j+1] = (3'(j) < count_upd[2:0]) ? bytes_upd[j] : 8'h00;
    end

    chunk_frame      = '0;
    chunk_frame.dest = tgt_cur;
    chunk_frame.done = 1'b0;
    if (short_start) begin
      chunk_frame.kind       = cpf_pkg::KIND_FILL;
      chunk_frame.len        = {1'b0, fill_upd} + 4'd1;
      chunk_frame.payload[0] = start[7:0];
      for (int j = 0; j < cpf_pkg::SHORT_CHUNK_CAP; j++) begin
        chunk_frame.payload[j+1] = (3'(j) < fill_upd) ? bytes_upd[j] : 8'h00;
      end
    end else begin
      chunk_frame.kind       = cpf_pkg::KIND_FILL_LONG;
      chunk_frame.len        = {1'b0, fill_upd} + 4'd2;
      chunk_frame.payload[0] = start[15:8];
      chunk_frame.payload[1] = start[7:0];
      for (int j = 0; j < cpf_pkg::LONG_CHUNK_CAP; j++) begin
        chunk_frame.payload[j+2] = (3'(j) < fill_upd) ? bytes_upd[j] : 8'h00;
      end
    end

    proc_frame            = '0;
    proc_frame.kind       = cpf_pkg::KIND_PROCESS;
    proc_frame.dest       = tgt_cur;
    proc_frame.len        = 4'(cpf_pkg::PROCESS_LEN);
    proc_frame.done       = 1'b1;
    proc_frame.payload[0] = own_id;
    proc_frame.payload[1] = cmd_cur;
    proc_frame.payload[2] = count_upd[15:8];
    proc_frame.payload[3] = count_upd[7:0];
    proc_frame.payload[4] = crc_next[15:8];
    proc_frame.payload[5] = crc_next[7:0];

    pair.second = proc_frame;
    pair.two    = emit_chunk && emit_proc;
    if (short_pkt) begin
      pair.first = short_frame;
    end else if (emit_chunk) begin
      pair.first = chunk_frame;
    end else begin
      pair.first = proc_frame;
    end
    push = accept && (short_pkt || emit_chunk || emit_proc);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < cpf_pkg::CHUNK_DEPTH; i++) begin
        chunk_bytes[i] <= bytes_upd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_fill      <= '0;
      byte_count      <= '0;
      running_crc     <= cpf_pkg::CRC_INIT_RESET;
      latched_target  <= 8'h00;
      latched_command <= 8'h00;
    end else if (accept) begin
      latched_target  <= tgt_cur;
      latched_command <= cmd_cur;
      if (last_byte) begin
        chunk_fill  <= '0;
        byte_count  <= '0;
        running_crc <= crc_init;
      end else begin
        chunk_fill  <= emit_chunk ? '0 : fill_upd;
        byte_count  <= count_upd;
        running_crc <= crc_next;
      end
    end
  end

  cpf_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pair (pair),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_frame (out_frame)
  );

  assign frame_kind   = out_frame.kind;
  assign dest_id      = out_frame.dest;
  assign frame_length = out_frame.len;
  assign payload_0    = out_frame.payload[0];
  assign payload_1    = out_frame.payload[1];
  assign payload_2    = out_frame.payload[2];
  assign payload_3    = out_frame.payload[3];
  assign payload_4    = out_frame.payload[4];
  assign payload_5    = out_frame.payload[5];
  assign payload_6    = out_frame.payload[6];
  assign payload_7    = out_frame.payload[7];
  assign packet_done  = out_frame.done;

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (byte_count == '0 && chunk_fill == '0))
    else $error("packet state not cleared after closing byte");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    chunk_fill != 3'd7)
    else $error("chunk not flushed when full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_COUNT)
    else $error("byte count beyond limit");

  a_short_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == cpf_pkg::KIND_SHORT) |-> packet_done)
    else $error("short frame without packet end");
`endif

endmodule
`default_nettype wire
